### sv/hcbd_pkg.sv
`default_nettype none

package hcbd_pkg;

  // Width limits and defaults
  localparam int LEN_BITS_DEFAULT = 32;
  localparam int BODY_LEN_W       = 32;

  // Characters of the line framing
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Bytes dropped after the data of each chunk
  localparam logic [1:0] TRAIL_BYTES = 2'd2;

  // Completion status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;

  // Decoder phases, one-hot
  typedef enum logic [6:0] {
    PH_SIZE    = 7'b0000001,
    PH_SIZE_CR = 7'b0000010,
    PH_DATA    = 7'b0000100,
    PH_SKIP    = 7'b0001000,
    PH_LAST    = 7'b0010000,
    PH_LAST_CR = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

  // Input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_body;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic       data_valid;
    logic [7:0] out_byte;
    logic       body_done;
    logic [1:0] status;
  } out_beat_t;

  // Hex digit decode: bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/hcbd_core.sv
`default_nettype none

module hcbd_core
  import hcbd_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [BODY_LEN_W-1:0] limit,
  input  wire in_beat_t              item,
  output out_beat_t                  result
);

  phase_t                phase, phase_next;
  logic [LEN_BITS-1:0]   chunk_remaining, chunk_remaining_next;
  logic                  digits_ended, digits_ended_next;
  logic [BODY_LEN_W-1:0] body_length, body_length_next;
  logic [1:0]            skip_count, skip_count_next;

  // state as seen by this byte, after an optional restart
  phase_t                cur_phase;
  logic [LEN_BITS-1:0]   cur_rem;
  logic                  cur_de;
  logic [BODY_LEN_W-1:0] cur_len;
  logic [1:0]            cur_skip;

  logic [4:0]            hex;
  logic [LEN_BITS-1:0]   rem_dec;
  logic [1:0]            skip_dec;

  always_comb begin
    if (item.start_of_body) begin
      cur_phase = PH_SIZE;
      cur_rem   = '0;
      cur_de    = 1'b0;
      cur_len   = '0;
      cur_skip  = '0;
    end else begin
      cur_phase = phase;
      cur_rem   = chunk_remaining;
      cur_de    = digits_ended;
      cur_len   = body_length;
      cur_skip  = skip_count;
    end
  end

  assign hex      = hex_decode(item.in_byte);
  assign rem_dec  = cur_rem - {{(LEN_BITS-1){1'b0}}, 1'b1};
  assign skip_dec = (cur_skip != 2'd0) ? cur_skip - 2'd1 : cur_skip;

  // per-byte decision
  always_comb begin
    phase_next           = cur_phase;
    chunk_remaining_next = cur_rem;
    digits_ended_next    = cur_de;
    body_length_next     = cur_len;
    skip_count_next      = cur_skip;
    result               = '0;

    unique case (cur_phase)
      PH_SIZE: begin
        if (!cur_de && hex[4]) begin
          // top nibble busy: one more digit would overflow
          if (cur_rem[LEN_BITS-1 -: 4] != 4'd0) begin
            result.body_done = 1'b1;
            result.status    = ST_OVERFLOW;
            phase_next       = PH_DONE;
          end else begin
            chunk_remaining_next = {cur_rem[LEN_BITS-5:0], hex[3:0]};
          end
        end else begin
          digits_ended_next = 1'b1;
          if (item.in_byte == CH_CR) begin
            phase_next = PH_SIZE_CR;
          end
        end
      end
      PH_SIZE_CR: begin
        if (item.in_byte == CH_LF) begin
          digits_ended_next = 1'b0;
          phase_next        = (cur_rem == '0) ? PH_LAST : PH_DATA;
        end else if (item.in_byte != CH_CR) begin
          phase_next = PH_SIZE;
        end
      end
      PH_DATA: begin
        result.data_valid = 1'b1;
        result.out_byte   = item.in_byte;
        if (cur_len != '1) begin
          body_length_next = cur_len + {{(BODY_LEN_W-1){1'b0}}, 1'b1};
        end
        chunk_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          skip_count_next = TRAIL_BYTES;
          phase_next      = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_count_next = skip_dec;
        if (skip_dec == 2'd0) begin
          chunk_remaining_next = '0;
          digits_ended_next    = 1'b0;
          phase_next           = PH_SIZE;
        end
      end
      PH_LAST: begin
        if (item.in_byte == CH_CR) begin
          phase_next = PH_LAST_CR;
        end
      end
      PH_LAST_CR: begin
        if (item.in_byte == CH_LF) begin
          result.body_done = 1'b1;
          result.status    = (limit != '0 && cur_len > limit) ? ST_TOO_LARGE : ST_OK;
          phase_next       = PH_DONE;
        end else if (item.in_byte != CH_CR) begin
          phase_next = PH_LAST;
        end
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  // state registers, updated once per processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      chunk_remaining <= '0;
      digits_ended    <= 1'b0;
      body_length     <= '0;
      skip_count      <= '0;
    end else if (step) begin
      phase           <= phase_next;
      chunk_remaining <= chunk_remaining_next;
      digits_ended    <= digits_ended_next;
      body_length     <= body_length_next;
      skip_count      <= skip_count_next;
    end
  end

endmodule

`default_nettype wire

### sv/http_chunked_body_decoder.sv
// Channel   Direction  Handshake              Payload
// body      in         body_valid/body_stall  body_beat  (in_byte, start_of_body)
// dec       out        dec_valid/dec_stall    dec_beat   (data_valid, out_byte,
//                                                         body_done, status)
// limit     in         limit_we               limit_data (body_limit)
//
// One result beat per input beat, one beat per cycle while dec_stall is low; each
// beat passes the input register, then the result register.
// Reset is synchronous on rst and returns the decoder to a fresh size line with
// no limit. dec_stall reaches body_stall through the input register in the same
// cycle; a stalled result beat holds while the next byte waits in the input register.
`default_nettype none

module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  body_valid,
  output logic                       body_stall,
  input  wire in_beat_t              body_beat,
  output logic                       dec_valid,
  input  wire logic                  dec_stall,
  output out_beat_t                  dec_beat,
  input  wire logic                  limit_we,
  input  wire logic [BODY_LEN_W-1:0] limit_data
);

  logic [BODY_LEN_W-1:0] body_limit;
  logic                  hold_valid;
  in_beat_t              hold_beat;
  out_beat_t             result;
  logic                  out_free;
  logic                  advance;

  // flow control
  assign out_free   = !dec_valid || !dec_stall;
  assign advance    = hold_valid && out_free;
  assign body_stall = hold_valid && !out_free;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      body_limit <= '0;
    end else if (limit_we) begin
      body_limit <= limit_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!body_stall) begin
      hold_valid <= body_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!body_stall && body_valid) begin
      hold_beat <= body_beat;
    end
  end

  hcbd_core #(
    .LEN_BITS (LEN_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .limit  (body_limit),
    .item   (hold_beat),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (out_free) begin
      dec_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dec_beat <= result;
    end
  end

`ifndef SYNTH
  // a data byte never also completes the body
  assert property (@(posedge clk) disable iff (rst)
    dec_valid |-> !(dec_beat.data_valid && dec_beat.body_done))
    else $error("data beat also flagged body_done");

  // status is only reported on the completing beat
  assert property (@(posedge clk) disable iff (rst)
    dec_valid && !dec_beat.body_done |-> dec_beat.status == ST_OK)
    else $error("status set without body_done");

  // a processed byte lands in the result register on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    advance |=> dec_valid)
    else $error("processed beat did not reach the output");

  // a waiting byte is kept while the output is blocked
  assert property (@(posedge clk) disable iff (rst)
    body_stall |=> hold_valid && $stable(hold_beat))
    else $error("held input beat lost during stall");
`endif

endmodule

`default_nettype wire
